@@ rtl/sac_pkg.sv @@
// Shared types and codes for the sorted array occurrence counter.
`timescale 1ns / 1ps

package sac_pkg;

    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned VALUE_W  = 32;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  first_index;
        logic                found;
        logic [COUNT_W-1:0]  match_count;
    } sac_result_t;

endpackage

@@ rtl/sac_store.sv @@
// Element memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module sac_store
    import sac_pkg::*;
#(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sac_ctrl.sv @@
// Command sequencer with the shared bound-search compare unit.
`timescale 1ns / 1ps

module sac_ctrl
    import sac_pkg::*;
#(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned FILL_W = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          in_cmd,
    input  logic signed [VALUE_W-1:0] in_value,
    output logic                      res_valid,
    input  logic                      res_ready,
    output sac_result_t               res,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output logic signed [VALUE_W-1:0] wr_data,
    output logic                      rd_en,
    output logic [ADDR_W-1:0]         rd_addr,
    input  logic signed [VALUE_W-1:0] rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CHECK,
        ST_DONE
    } state_t;

    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(DEPTH);

    state_t                    state_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic signed [VALUE_W-1:0] last_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [FILL_W-1:0]         lo_reg;
    logic [FILL_W-1:0]         hi_reg;
    logic [FILL_W-1:0]         mid_reg;
    logic [FILL_W-1:0]         lb_reg;
    logic                      strict_reg;
    sac_result_t               res_reg;

    logic [FILL_W-1:0]   span;
    logic [FILL_W-1:0]   mid;
    logic                searching;
    logic                go_right;
    logic                accept;
    logic [FILL_W-1:0]   count_fill;
    logic [31:0]         count_wide;
    logic [31:0]         first_wide;
    logic [STATUS_W-1:0] append_status;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign span      = hi_reg - lo_reg;
    assign mid       = lo_reg + (span >> 1);
    assign searching = (lo_reg < hi_reg);

    // Lower bound moves right past elements below the key, upper bound also
    // past elements equal to it.
    assign go_right = strict_reg ? (rd_data <= key_reg) : (rd_data < key_reg);

    assign count_fill = lo_reg - lb_reg;
    assign count_wide = 32'(count_fill);
    assign first_wide = 32'(lb_reg);

    // A full store rejects as full even when the value is also out of order.
    assign append_status = (fill_reg == FULL_LEVEL) ? STATUS_FULL :
                           ((fill_reg != '0) && (in_value < last_reg)) ? STATUS_ORDER :
                           STATUS_OK;

    assign rd_en   = (state_reg == ST_ISSUE) && searching;
    assign rd_addr = mid[ADDR_W-1:0];

    assign wr_en   = accept && (in_cmd == CMD_APPEND) && (append_status == STATUS_OK);
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = in_value;

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            last_reg   <= '0;
            key_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            lb_reg     <= '0;
            strict_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg.match_count <= '0;
                        res_reg.found       <= 1'b0;
                        res_reg.first_index <= '0;
                        res_reg.status      <= (in_cmd == CMD_APPEND) ? append_status
                                                                      : STATUS_OK;
                        key_reg    <= in_value;
                        lo_reg     <= '0;
                        hi_reg     <= fill_reg;
                        lb_reg     <= '0;
                        strict_reg <= 1'b0;
                        state_reg  <= (in_cmd == CMD_QUERY) ? ST_ISSUE : ST_DONE;
                        unique case (in_cmd)
                            CMD_APPEND:
                            begin
                                if (append_status == STATUS_OK)
                                begin
                                    last_reg <= in_value;
                                    fill_reg <= fill_reg + 1'b1;
                                end
                            end
                            CMD_QUERY:
                            begin
                                // The search window is loaded above.
                            end
                            CMD_CLEAR:
                            begin
                                fill_reg <= '0;
                            end
                            default:
                            begin
                                // Unused command: fill level and store unchanged, all-zero result.
                            end
                        endcase
                    end
                end
                ST_ISSUE:
                begin
                    if (searching)
                    begin
                        mid_reg   <= mid;
                        state_reg <= ST_CHECK;
                    end
                    else if (!strict_reg)
                    begin
                        // The upper bound cannot lie below the lower bound, so
                        // the second search starts there.
                        lb_reg     <= lo_reg;
                        hi_reg     <= fill_reg;
                        strict_reg <= 1'b1;
                    end
                    else
                    begin
                        res_reg.match_count <= count_wide[COUNT_W-1:0];
                        res_reg.found       <= (count_fill != '0);
                        res_reg.first_index <= (count_fill != '0) ?
                                               first_wide[INDEX_W-1:0] : '0;
                        res_reg.status      <= STATUS_OK;
                        state_reg           <= ST_DONE;
                    end
                end
                ST_CHECK:
                begin
                    if (go_right)
                    begin
                        lo_reg <= mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= ST_ISSUE;
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_LEVEL)
        else $error("fill level beyond store depth");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (lo_reg < hi_reg) && (mid_reg < fill_reg))
        else $error("probe outside the searched window");

    a_window_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (hi_reg <= fill_reg) && (lo_reg <= hi_reg))
        else $error("search window outside filled part");

    a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (res_reg.found == (res_reg.match_count != '0)))
        else $error("found flag disagrees with count");

    a_rejected_has_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_reg.status != STATUS_OK) |->
            (res_reg.match_count == '0) && !res_reg.found)
        else $error("rejected append carries a count");
`endif

endmodule

@@ rtl/sorted_array_occurrence_count_top.sv @@
// Append, clear and unused commands go from acceptance to the done state and then through
//   the output register. A query runs a lower-bound search and then an upper-bound search,
//   each of at most log2(STORE_DEPTH) + 1 probes, before its result goes the same way.
// One transaction at a time: each probe is a read on the store's read port followed by a
//   compare, and the next item is taken once the result is handed off.
// Reset: the fill level and all control state clear; stored elements are left as they are.
`timescale 1ns / 1ps

module sorted_array_occurrence_count_top
    import sac_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [10:0] match_count, [11] found,
                                   // [21:12] first_index, [23:22] status
);

    localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      res_valid;
    logic                      res_ready;
    sac_result_t               res;

    logic                      m_tvalid_reg;
    sac_result_t               out_reg;

    sac_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sac_ctrl #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .FILL_W (FILL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_value  ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // The output register frees the sequencer as soon as a result is loaded.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                m_tvalid_reg <= 1'b1;
                out_reg      <= res;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule
